// ----- design/mca_pkg.sv -----
// Shared constants, action codes and stage-enable type for the modular
// coefficient ALU. No dependencies.
package mca_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned ProdW = 64;
    localparam int unsigned ActW  = 3;

    localparam logic [ActW-1:0] ActAdd    = 3'd0;
    localparam logic [ActW-1:0] ActSub    = 3'd1;
    localparam logic [ActW-1:0] ActNeg    = 3'd2;
    localparam logic [ActW-1:0] ActReduce = 3'd3;
    localparam logic [ActW-1:0] ActCsubq  = 3'd4;
    localparam logic [ActW-1:0] ActCaddq  = 3'd5;
    localparam logic [ActW-1:0] ActFreeze = 3'd6;
    localparam logic [ActW-1:0] ActMont   = 3'd7;

    localparam int unsigned TopShift  = 30;
    localparam int unsigned FoldShift = 18;
    localparam int unsigned SignBit   = 31;

    localparam logic [DataW-1:0]        ModQ     = 32'd1073479681;
    localparam logic [DataW-1:0]        ModQInv  = 32'hC0040001;
    localparam logic signed [DataW-1:0] HalfQ    = 32'sd536739840;
    localparam logic signed [ProdW-1:0] ModQWide = 64'sd1073479681;
    localparam logic [DataW-1:0]        LowMask  = (32'd1 << TopShift) - 32'd1;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

endpackage

// ----- design/modular_coefficient_alu.sv -----
// Per-coefficient modular ALU, q = 2^30 - 2^18 + 1. Top level: stage valid
// chain and handshakes. Depends on mca_pkg, mca_fold_alu, mca_mont_pipe.
//
// Usage:
//   Input channel in_valid/in_ready carries action, operand_a, operand_b.
//   Output channel out_valid/out_ready carries result. One transfer in gives
//   exactly one transfer out, in order.
//   Every action goes through the same four stages (product, m = low*qinv,
//   m*q, subtract); out_valid rises once the item reaches the last stage.
//   Throughput: one item per cycle while out_ready stays high; each stage
//   holds one multiplier or one 64-bit subtract.
//   Each stage advances when it is empty or the next stage advances, so
//   bubbles collapse: in_ready stays high while any stage has room, even
//   with a finished result waiting at the output.
//   When out_ready is low the result holds; upstream stages fill, then
//   in_ready drops. Nothing is dropped or repeated.
//   Reset (rst_n low, asynchronous) empties all stages; in_ready is high
//   right after reset.
module modular_coefficient_alu (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [mca_pkg::ActW-1:0]         action,
    input  logic signed [mca_pkg::DataW-1:0] operand_a,
    input  logic signed [mca_pkg::DataW-1:0] operand_b,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [mca_pkg::DataW-1:0] result
);

    mca_pkg::pipe_en_t         en;
    logic                      v1_reg, v2_reg, v3_reg, v4_reg;
    logic                      v1_next, v2_next, v3_next, v4_next;
    logic [mca_pkg::DataW-1:0] simple_result;
    logic [mca_pkg::DataW-1:0] result_raw;
    logic                      is_mont;

    assign en.s4 = !v4_reg || out_ready;
    assign en.s3 = !v3_reg || en.s4;
    assign en.s2 = !v2_reg || en.s3;
    assign en.s1 = !v1_reg || en.s2;

    assign v1_next = en.s1 ? in_valid : v1_reg;
    assign v2_next = en.s2 ? v1_reg   : v2_reg;
    assign v3_next = en.s3 ? v2_reg   : v3_reg;
    assign v4_next = en.s4 ? v3_reg   : v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign is_mont = (action == mca_pkg::ActMont);

    mca_fold_alu u_fold_alu (
        .action        (action),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .simple_result (simple_result)
    );

    mca_mont_pipe u_mont_pipe (
        .clk           (clk),
        .en            (en),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .simple_result (simple_result),
        .is_mont       (is_mont),
        .result        (result_raw)
    );

    assign in_ready  = en.s1;
    assign out_valid = v4_reg;
    assign result    = signed'(result_raw);

    // empty output means every stage advances
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v4_reg |-> in_ready)
        else $error("in_ready low with empty output stage");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("accepted transfer not captured in first stage");

    a_stall_keeps_s3: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && v4_reg && !out_ready) |=> (v3_reg && v4_reg))
        else $error("item lost under output stall");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && !out_ready) |-> !in_ready)
        else $error("input accepted into a full stalled pipeline");

endmodule

// ----- design/mca_fold_alu.sv -----
// Combinational logic for the add/sub/negate/reduce/csubq/caddq/freeze actions.
// Depends on mca_pkg.
module mca_fold_alu (
    input  logic [mca_pkg::ActW-1:0]         action,
    input  logic signed [mca_pkg::DataW-1:0] operand_a,
    input  logic signed [mca_pkg::DataW-1:0] operand_b,
    output logic [mca_pkg::DataW-1:0]        simple_result
);

    logic [mca_pkg::DataW-1:0] fold_in;
    logic [mca_pkg::DataW-1:0] top_ext;
    logic [mca_pkg::DataW-1:0] folded;
    logic [mca_pkg::DataW-1:0] csub_diff;

    always_comb
    begin
        case (action)
            mca_pkg::ActAdd: fold_in = operand_a + operand_b;
            mca_pkg::ActSub: fold_in = operand_a - operand_b;
            default:         fold_in = operand_a;
        endcase
    end

    // t = v >> 30, arithmetic
    assign top_ext = {{(mca_pkg::DataW-2){fold_in[mca_pkg::SignBit]}},
                      fold_in[mca_pkg::SignBit:mca_pkg::TopShift]};
    assign folded  = (fold_in & mca_pkg::LowMask) - top_ext
                     + (top_ext << mca_pkg::FoldShift);

    // a - q, kept only when it stays non-negative
    assign csub_diff = operand_a - mca_pkg::ModQ;

    always_comb
    begin
        case (action) inside
            mca_pkg::ActAdd, mca_pkg::ActSub, mca_pkg::ActReduce:
                simple_result = folded;
            mca_pkg::ActNeg:
                simple_result = '0 - operand_a;
            mca_pkg::ActCsubq:
                simple_result = csub_diff[mca_pkg::SignBit] ? operand_a : csub_diff;
            mca_pkg::ActCaddq:
                simple_result = operand_a[mca_pkg::SignBit] ? operand_a + mca_pkg::ModQ
                                                            : operand_a;
            mca_pkg::ActFreeze:
                simple_result = (operand_a > mca_pkg::HalfQ) ? operand_a - mca_pkg::ModQ
                                                             : operand_a;
            default:
                simple_result = operand_a;
        endcase
    end

endmodule

// ----- design/mca_mont_pipe.sv -----
// Four-stage datapath: a*b, m = low(ab)*qinv, m*q, high half of ab - mq.
// Carries the combinational action result alongside. Depends on mca_pkg.
module mca_mont_pipe (
    input  logic                             clk,
    input  mca_pkg::pipe_en_t                en,
    input  logic signed [mca_pkg::DataW-1:0] operand_a,
    input  logic signed [mca_pkg::DataW-1:0] operand_b,
    input  logic [mca_pkg::DataW-1:0]        simple_result,
    input  logic                             is_mont,
    output logic [mca_pkg::DataW-1:0]        result
);

    logic signed [mca_pkg::ProdW-1:0] prod1_next;
    logic signed [mca_pkg::ProdW-1:0] prod1_reg;
    logic [mca_pkg::DataW-1:0]        simple1_reg;
    logic                             mont1_reg;

    logic [mca_pkg::DataW-1:0]        m2_next;
    logic [mca_pkg::DataW-1:0]        m2_reg;
    logic signed [mca_pkg::ProdW-1:0] prod2_reg;
    logic [mca_pkg::DataW-1:0]        simple2_reg;
    logic                             mont2_reg;

    logic signed [mca_pkg::ProdW-1:0] mq3_next;
    logic signed [mca_pkg::ProdW-1:0] mq3_reg;
    logic signed [mca_pkg::ProdW-1:0] prod3_reg;
    logic [mca_pkg::DataW-1:0]        simple3_reg;
    logic                             mont3_reg;

    logic [mca_pkg::ProdW-1:0]        diff;
    logic [mca_pkg::DataW-1:0]        result_next;
    logic [mca_pkg::DataW-1:0]        result_reg;

    assign prod1_next = mca_pkg::ProdW'(operand_a) * mca_pkg::ProdW'(operand_b);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prod1_reg   <= prod1_next;
            simple1_reg <= simple_result;
            mont1_reg   <= is_mont;
        end
    end

    assign m2_next = prod1_reg[mca_pkg::DataW-1:0] * mca_pkg::ModQInv;

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            m2_reg      <= m2_next;
            prod2_reg   <= prod1_reg;
            simple2_reg <= simple1_reg;
            mont2_reg   <= mont1_reg;
        end
    end

    assign mq3_next = mca_pkg::ProdW'(signed'(m2_reg)) * mca_pkg::ModQWide;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            mq3_reg     <= mq3_next;
            prod3_reg   <= prod2_reg;
            simple3_reg <= simple2_reg;
            mont3_reg   <= mont2_reg;
        end
    end

    assign diff        = prod3_reg - mq3_reg;
    assign result_next = mont3_reg ? diff[mca_pkg::ProdW-1:mca_pkg::DataW] : simple3_reg;

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
